// File: src/wsse_pkg.sv
// ----------------------------------------------------------------------------
// wsse_pkg
// shared types, tags and codes of the wav stream sample extractor
// ----------------------------------------------------------------------------
`default_nettype none

package wsse_pkg;

  localparam int MAX_CHANNELS_DEF = 2;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [15:0] FMT_PCM   = 16'h0001;
  localparam logic [15:0] FMT_FLOAT = 16'h0003;
  localparam logic [15:0] FMT_EXT   = 16'hFFFE;

  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_HEADER     = 3'd1;
  localparam logic [2:0] ERR_MISSING    = 3'd2;
  localparam logic [2:0] ERR_COMPRESSED = 3'd3;
  localparam logic [2:0] ERR_DEPTH      = 3'd4;

  localparam logic [1:0] CFG_SEL    = 2'd0;
  localparam logic [1:0] CFG_START  = 2'd1;
  localparam logic [1:0] CFG_BUDGET = 2'd2;

  localparam int DIV_STEPS  = 32;
  localparam int NORM_STEPS = 5;

  typedef enum logic [2:0] {
    PH_HDR, PH_CHDR, PH_FMT, PH_SKIP, PH_PAD, PH_DATA, PH_DRAIN
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_DFIN, ST_NORM, ST_CFIN
  } state_t;

  typedef enum logic [1:0] {
    KIND_SAMPLE, KIND_INFO, KIND_ERROR, KIND_SHORT
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] value;
    logic        last;
    logic [2:0]  err;
    logic [1:0]  ch;
    logic [30:0] rate;
    logic [31:0] frames;
    logic        flt;
    logic [2:0]  bps;
  } res_t;

  typedef struct packed {
    logic       take;
    logic       div_step;
    logic       norm_step;
    logic [2:0] norm_idx;
    logic       fin_div;
    logic       fin_cvt;
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic need_cvt;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// File: src/wsse_ctrl.sv
// ----------------------------------------------------------------------------
// wsse_ctrl
// sequencer: byte accept, frame divide, sample normalize, result hand-off
// ----------------------------------------------------------------------------
`default_nettype none

module wsse_ctrl
  import wsse_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic      in_tready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t     st_r, st_nxt;
  logic [4:0] cnt_r, cnt_nxt;

  always_comb begin
    st_nxt  = st_r;
    cnt_nxt = cnt_r + 5'd1;
    case (st_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (cmd.take && sts.need_div) begin
          st_nxt = ST_DIV;
        end else if (cmd.take && sts.need_cvt) begin
          st_nxt = ST_NORM;
        end
      end
      ST_DIV: begin
        if (cnt_r == 5'(DIV_STEPS - 1)) begin
          st_nxt = ST_DFIN;
        end
      end
      ST_NORM: begin
        if (cnt_r == 5'(NORM_STEPS - 1)) begin
          st_nxt = ST_CFIN;
        end
      end
      ST_DFIN, ST_CFIN: begin
        if (sts.out_free) begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = (st_r == ST_IDLE) && sts.out_free;
    cmd.take  = in_tvalid && in_tready;
    cmd.norm_idx = cnt_r[2:0];
    case (st_r)
      ST_DIV:  cmd.div_step  = 1'b1;
      ST_NORM: cmd.norm_step = 1'b1;
      ST_DFIN: cmd.fin_div   = sts.out_free;
      ST_CFIN: cmd.fin_cvt   = sts.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_IDLE;
      cnt_r <= '0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
    end
  end

`ifndef SYNTH
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (st_r == ST_IDLE))
    else $error("input ready outside idle");
  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_DIV && cnt_r == 5'(DIV_STEPS - 1)) |=> (st_r == ST_DFIN))
    else $error("divide did not finish on time");
  a_fin_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.fin_div || cmd.fin_cvt) |-> sts.out_free)
    else $error("result load while output busy");
`endif

endmodule

`default_nettype wire

// File: src/wsse_dpath.sv
// ----------------------------------------------------------------------------
// wsse_dpath
// chunk parser registers, frame divider, pcm to float converter, output register
// ----------------------------------------------------------------------------
`default_nettype none

module wsse_dpath
  import wsse_pkg::*;
#(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cmd_t        cmd,
  output sts_t             sts,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_last,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  output res_t             out_res,
  output logic             out_valid,
  input  wire logic        out_ready
);

  localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int DIVR_W = $clog2(4 * MAX_CHANNELS + 1);

  logic        selch_r;
  logic [31:0] start_r, budget_r;

  phase_t      phase_r, phase_nxt;
  logic [31:0] pos_r, pos_nxt, tag_r, tag_nxt, len_r, len_nxt;
  logic [15:0] fmt_r, fmt_nxt, chan_r, chan_nxt, depth_r, depth_nxt;
  logic [31:0] rate_r, rate_nxt, ftot_r, ftot_nxt, fidx_r, fidx_nxt;
  logic [31:0] gath_r, gath_nxt, wfrom_r, wfrom_nxt, wend_r, wend_nxt;
  logic [1:0]  off_r, off_nxt;
  logic [CH_W-1:0] chn_r, chn_nxt;
  logic        riff_r, riff_nxt, flt_r, flt_nxt, pend_r, pend_nxt;
  logic [2:0]  sbytes_r, sbytes_nxt;

  logic [31:0]       dq_r, dq_nxt;
  logic [DIVR_W-1:0] drem_r, drem_nxt, ddiv_r, ddiv_nxt;
  logic [DIVR_W:0]   rem_sh;

  logic [31:0] cm_r, cm_nxt;
  logic [7:0]  cexp_r, cexp_nxt;
  logic        csign_r, csign_nxt, clast_r, clast_nxt;

  res_t        res, res_r;
  logic        res_ld, valid_r;
  logic        out_free;

  logic [31:0] p, gsmp, sx, want;
  logic [CH_W-1:0] sel;
  logic        frame_end, depth_ok, is_fl, wlast, rup;

  assign out_free = !valid_r || out_ready;

  always_comb begin
    phase_nxt = phase_r; pos_nxt = pos_r; tag_nxt = tag_r; len_nxt = len_r;
    fmt_nxt = fmt_r; chan_nxt = chan_r; depth_nxt = depth_r; rate_nxt = rate_r;
    ftot_nxt = ftot_r; fidx_nxt = fidx_r; gath_nxt = gath_r; wfrom_nxt = wfrom_r;
    wend_nxt = wend_r; off_nxt = off_r; chn_nxt = chn_r; riff_nxt = riff_r;
    flt_nxt = flt_r; pend_nxt = pend_r; sbytes_nxt = sbytes_r;
    dq_nxt = dq_r; drem_nxt = drem_r; ddiv_nxt = ddiv_r;
    cm_nxt = cm_r; cexp_nxt = cexp_r; csign_nxt = csign_r; clast_nxt = clast_r;
    res = '0; res_ld = 1'b0;
    sts = '0;
    sts.out_free = out_free;
    p = pos_r;
    gsmp = '0; sx = '0; want = '0; wlast = 1'b0; rup = 1'b0;
    is_fl = (fmt_r == FMT_FLOAT);
    depth_ok = is_fl ? (depth_r == 16'd32) : (depth_r inside {16'd8, 16'd16, 16'd24, 16'd32});
    sel = ({15'd0, selch_r} < chan_r) ? CH_W'(selch_r) : '0;
    frame_end = (off_r == 2'(sbytes_r - 3'd1)) && (chn_r == CH_W'(chan_r - 16'd1));
    rem_sh = {drem_r, dq_r[31]};

    if (cmd.take) begin
      case (phase_r)
        PH_HDR: begin
          tag_nxt = {in_byte, tag_r[31:8]};
          if (p == 32'd3) riff_nxt = (tag_nxt == TAG_RIFF);
          if (p == 32'd11) begin
            if (riff_r && tag_nxt == TAG_WAVE) begin
              phase_nxt = PH_CHDR;
              pos_nxt   = '0;
            end else begin
              res.kind = KIND_ERROR; res.err = ERR_HEADER; res_ld = 1'b1;
              phase_nxt = PH_DRAIN;
            end
          end else begin
            pos_nxt = p + 32'd1;
          end
        end
        PH_CHDR: begin
          pos_nxt = p + 32'd1;
          if (p < 32'd4) begin
            tag_nxt = {in_byte, tag_r[31:8]};
            if (p == 32'd0) len_nxt = '0;
          end else begin
            len_nxt = len_r | ({24'd0, in_byte} << {p[1:0], 3'b000});
            if (p == 32'd7) begin
              pos_nxt = '0;
              if (tag_r == TAG_FMT && len_nxt >= 32'd16) begin
                phase_nxt = PH_FMT;
              end else if (tag_r == TAG_DATA) begin
                if (chan_r == 16'd0 || chan_r > 16'(MAX_CHANNELS) || rate_r == 32'd0 ||
                    rate_r[31] || depth_r < 16'd8) begin
                  res.kind = KIND_ERROR; res.err = ERR_MISSING; res_ld = 1'b1;
                  phase_nxt = PH_DRAIN;
                end else if (!(fmt_r == FMT_PCM || is_fl)) begin
                  res.kind = KIND_ERROR; res.err = ERR_COMPRESSED; res_ld = 1'b1;
                  phase_nxt = PH_DRAIN;
                end else if (!depth_ok) begin
                  res.kind = KIND_ERROR; res.err = ERR_DEPTH; res_ld = 1'b1;
                  phase_nxt = PH_DRAIN;
                end else begin
                  sts.need_div = 1'b1;
                  dq_nxt   = len_nxt;
                  drem_nxt = '0;
                  ddiv_nxt = DIVR_W'(32'(depth_r[5:3]) * 32'(chan_r));
                end
              end else if (len_nxt == 32'd0) begin
                phase_nxt = PH_CHDR;
              end else begin
                phase_nxt = PH_SKIP;
              end
            end
          end
        end
        PH_FMT: begin
          case (p)
            32'd0:  fmt_nxt[7:0]    = in_byte;
            32'd1:  fmt_nxt[15:8]   = in_byte;
            32'd2:  chan_nxt[7:0]   = in_byte;
            32'd3:  chan_nxt[15:8]  = in_byte;
            32'd4:  rate_nxt[7:0]   = in_byte;
            32'd5:  rate_nxt[15:8]  = in_byte;
            32'd6:  rate_nxt[23:16] = in_byte;
            32'd7:  rate_nxt[31:24] = in_byte;
            32'd14: depth_nxt[7:0]  = in_byte;
            32'd15: depth_nxt[15:8] = in_byte;
            32'd24: gath_nxt = {24'd0, in_byte};
            32'd25: if (fmt_r == FMT_EXT) fmt_nxt = {in_byte, gath_r[7:0]};
            default: ;
          endcase
          if (p + 32'd1 == len_r) begin
            gath_nxt  = '0;
            phase_nxt = len_r[0] ? PH_PAD : PH_CHDR;
            pos_nxt   = '0;
          end else begin
            pos_nxt = p + 32'd1;
          end
        end
        PH_SKIP: begin
          if (p + 32'd1 == len_r) begin
            phase_nxt = len_r[0] ? PH_PAD : PH_CHDR;
            pos_nxt   = '0;
          end else begin
            pos_nxt = p + 32'd1;
          end
        end
        PH_PAD: begin
          phase_nxt = PH_CHDR;
          pos_nxt   = '0;
        end
        PH_DATA: begin
          if (chn_r == sel) gath_nxt = gath_r | ({24'd0, in_byte} << {off_r, 3'b000});
          gsmp = gath_nxt;
          if (off_r != 2'(sbytes_r - 3'd1)) begin
            off_nxt = off_r + 2'd1;
          end else begin
            off_nxt = '0;
            chn_nxt = chn_r + CH_W'(1);
          end
          if (frame_end) begin
            chn_nxt = '0;
            wlast = (fidx_r + 32'd1 == wend_r);
            if (fidx_r >= wfrom_r) begin
              if (flt_r) begin
                res.kind = KIND_SAMPLE; res.value = gsmp; res.last = wlast; res_ld = 1'b1;
              end else begin
                sts.need_cvt = 1'b1;
                case (sbytes_r)
                  3'd1:    sx = {{24{~gsmp[7]}}, ~gsmp[7], gsmp[6:0]};
                  3'd2:    sx = {{16{gsmp[15]}}, gsmp[15:0]};
                  3'd3:    sx = {{8{gsmp[23]}}, gsmp[23:0]};
                  default: sx = gsmp;
                endcase
                csign_nxt = sx[31];
                cm_nxt    = sx[31] ? (~sx + 32'd1) : sx;
                cexp_nxt  = 8'd159 - 8'({sbytes_r, 3'b000});
                clast_nxt = wlast;
              end
            end
            fidx_nxt = fidx_r + 32'd1;
            gath_nxt = '0;
            if (fidx_nxt >= wend_r) phase_nxt = PH_DRAIN;
          end
        end
        default: ;
      endcase

      if (in_last) begin
        if (!res_ld && !sts.need_div && !sts.need_cvt) begin
          if (phase_nxt == PH_HDR) begin
            res.kind = KIND_ERROR; res.err = ERR_HEADER; res_ld = 1'b1;
          end else if (phase_nxt == PH_DATA) begin
            res.kind = KIND_SHORT; res_ld = 1'b1;
          end else if (phase_nxt != PH_DRAIN) begin
            res.kind = KIND_ERROR; res.err = ERR_MISSING; res_ld = 1'b1;
          end
        end
        if (sts.need_div) pend_nxt = 1'b1;
      end
    end

    if (cmd.div_step) begin
      if (rem_sh >= {1'b0, ddiv_r}) begin
        drem_nxt = DIVR_W'(rem_sh - {1'b0, ddiv_r});
        dq_nxt   = {dq_r[30:0], 1'b1};
      end else begin
        drem_nxt = DIVR_W'(rem_sh);
        dq_nxt   = {dq_r[30:0], 1'b0};
      end
    end

    if (cmd.norm_step) begin
      case (cmd.norm_idx)
        3'd0: if (cm_r[31:16] == '0) begin cm_nxt = {cm_r[15:0], 16'd0}; cexp_nxt = cexp_r - 8'd16; end
        3'd1: if (cm_r[31:24] == '0) begin cm_nxt = {cm_r[23:0], 8'd0}; cexp_nxt = cexp_r - 8'd8; end
        3'd2: if (cm_r[31:28] == '0) begin cm_nxt = {cm_r[27:0], 4'd0}; cexp_nxt = cexp_r - 8'd4; end
        3'd3: if (cm_r[31:30] == '0) begin cm_nxt = {cm_r[29:0], 2'd0}; cexp_nxt = cexp_r - 8'd2; end
        3'd4: if (!cm_r[31]) begin cm_nxt = {cm_r[30:0], 1'b0}; cexp_nxt = cexp_r - 8'd1; end
        default: ;
      endcase
    end

    if (cmd.fin_cvt) begin
      rup = cm_r[7] & ((|cm_r[6:0]) | cm_r[8]);
      res.kind  = KIND_SAMPLE;
      res.value = (cm_r == '0) ? '0 : ({csign_r, cexp_r, cm_r[30:8]} + {31'd0, rup});
      res.last  = clast_r;
      res_ld    = 1'b1;
    end

    if (cmd.fin_div) begin
      res_ld = 1'b1;
      if (dq_r == '0) begin
        res.kind = KIND_ERROR; res.err = ERR_MISSING;
        phase_nxt = PH_DRAIN;
      end else begin
        ftot_nxt   = dq_r;
        sbytes_nxt = depth_r[5:3];
        flt_nxt    = is_fl;
        fidx_nxt   = '0; off_nxt = '0; chn_nxt = '0; gath_nxt = '0;
        if (budget_r == '0 || start_r >= dq_r) begin
          phase_nxt = PH_DRAIN;
        end else begin
          want      = dq_r - start_r;
          if (budget_r < want) want = budget_r;
          wfrom_nxt = start_r;
          wend_nxt  = start_r + want;
          phase_nxt = PH_DATA;
        end
        res.kind   = KIND_INFO;
        res.ch     = chan_r[1:0];
        res.rate   = rate_r[30:0];
        res.frames = dq_r;
        res.flt    = is_fl;
        res.bps    = depth_r[5:3];
      end
    end

    if ((cmd.take && in_last && !sts.need_div) || (cmd.fin_div && pend_r)) begin
      phase_nxt = PH_HDR; pos_nxt = '0; tag_nxt = '0; len_nxt = '0;
      fmt_nxt = '0; chan_nxt = '0; depth_nxt = '0; rate_nxt = '0;
      ftot_nxt = '0; fidx_nxt = '0; gath_nxt = '0; wfrom_nxt = '0;
      wend_nxt = '0; off_nxt = '0; chn_nxt = '0; riff_nxt = 1'b0;
      flt_nxt = 1'b0; sbytes_nxt = '0; pend_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      selch_r  <= 1'b0;
      start_r  <= '0;
      budget_r <= '1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SEL:    selch_r  <= cfg_data[0];
        CFG_START:  start_r  <= cfg_data;
        CFG_BUDGET: budget_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR; pos_r <= '0; tag_r <= '0; len_r <= '0;
      fmt_r <= '0; chan_r <= '0; depth_r <= '0; rate_r <= '0;
      ftot_r <= '0; fidx_r <= '0; gath_r <= '0; wfrom_r <= '0;
      wend_r <= '0; off_r <= '0; chn_r <= '0; riff_r <= 1'b0;
      flt_r <= 1'b0; pend_r <= 1'b0; sbytes_r <= '0;
      valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt; pos_r <= pos_nxt; tag_r <= tag_nxt; len_r <= len_nxt;
      fmt_r <= fmt_nxt; chan_r <= chan_nxt; depth_r <= depth_nxt; rate_r <= rate_nxt;
      ftot_r <= ftot_nxt; fidx_r <= fidx_nxt; gath_r <= gath_nxt; wfrom_r <= wfrom_nxt;
      wend_r <= wend_nxt; off_r <= off_nxt; chn_r <= chn_nxt; riff_r <= riff_nxt;
      flt_r <= flt_nxt; pend_r <= pend_nxt; sbytes_r <= sbytes_nxt;
      if (res_ld) begin
        valid_r <= 1'b1;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    dq_r <= dq_nxt; drem_r <= drem_nxt; ddiv_r <= ddiv_nxt;
    cm_r <= cm_nxt; cexp_r <= cexp_nxt; csign_r <= csign_nxt; clast_r <= clast_nxt;
    if (res_ld) res_r <= res;
  end

  assign out_res   = res_r;
  assign out_valid = valid_r;

endmodule

`default_nettype wire

// File: src/wav_stream_sample_extractor_unit.sv
// ----------------------------------------------------------------------------
// wav_stream_sample_extractor_unit
// riff/wave byte stream parser giving stream info, errors and float samples
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  in_     | in  | tdata: data_byte, tlast: end_of_file
//  out_    | out | tuser: result_kind, tlast: last_sample, tdata: stream fields
//  cfg_    | in  | write enable, register index, 32-bit data
//
//  one byte per cycle in all parse phases while the sequencer is idle
//  data header: restoring divide for total frames, then info item
//  pcm sample (not float): shift normalize, then round to float
//  input stalls while out_tvalid is high and out_tready low, and during divide and normalize
//  synchronous active-low reset, no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module wav_stream_sample_extractor_unit
  import wsse_pkg::*;
#(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [7:0]   in_tdata,   // data_byte
  input  wire logic         in_tlast,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // sample_value, error_code, channel_count, sample_rate, total_frames,
  // is_float, sample_bytes
  output logic [103:0]      out_tdata,
  output logic [1:0]        out_tuser,  // result_kind
  output logic              out_tlast,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [31:0]  cfg_data
);

  cmd_t cmd;
  sts_t sts;
  res_t res;

  wsse_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  wsse_dpath #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_byte   (in_tdata),
    .in_last   (in_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_res   (res),
    .out_valid (out_tvalid),
    .out_ready (out_tready)
  );

  assign out_tdata = {res.bps, res.flt, res.frames, res.rate, res.ch, res.err, res.value};
  assign out_tuser = res.kind;
  assign out_tlast = res.last;

endmodule

`default_nettype wire
